// ----- hdl/rfl_pkg.sv -----
// package for the ring free-list allocator
// holds pool size, derived widths, request codes and the result record; no dependencies
package rfl_pkg;

  // pool size and the widths of pointers, indices and counters
  localparam int BUFFERS = 16;
  localparam int PTR_W   = $clog2(BUFFERS);
  localparam int IDX_W   = 4;
  localparam int CNT_W   = $clog2(BUFFERS + 1);
  localparam int CORR_W  = 16;

  // request codes
  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  // result of one request
  typedef struct packed {
    logic              ok;
    logic [IDX_W-1:0]  buffer_index;
    logic [CNT_W-1:0]  free_count;
    logic [CORR_W-1:0] corrupt_count;
  } res_t;

endpackage

// ----- hdl/rfl_ring.sv -----
// slot ring with take/return pointers and the dropped-release counter
// computes one request's result and updates the ring; depends on rfl_pkg
module rfl_ring (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      exec,
  input  logic                      op,
  input  logic [rfl_pkg::IDX_W-1:0] rel_index,
  output rfl_pkg::res_t             res
);
  import rfl_pkg::*;

  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(BUFFERS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(BUFFERS);
  localparam logic [CORR_W-1:0] CORR_MAX = '1;

  logic [IDX_W-1:0]   slot_idx_r [BUFFERS];
  logic [BUFFERS-1:0] slot_full_r, slot_full_nxt;
  logic [PTR_W-1:0]   take_r, take_nxt;
  logic [PTR_W-1:0]   ret_r, ret_nxt;
  logic [CORR_W-1:0]  corr_r, corr_nxt;
  logic               do_alloc, do_store;
  logic [CNT_W-1:0]   free_cnt;

  // request decode against current ring state
  always_comb begin
    do_alloc      = (op_t'(op) == OP_ALLOC) && slot_full_r[take_r];
    do_store      = (op_t'(op) == OP_RELEASE) && !slot_full_r[ret_r];
    slot_full_nxt = slot_full_r;
    take_nxt      = take_r;
    ret_nxt       = ret_r;
    corr_nxt      = corr_r;
    if (do_alloc) begin
      slot_full_nxt[take_r] = 1'b0;
      take_nxt = (take_r == LAST_PTR) ? '0 : take_r + 1'b1;
    end
    if (do_store) begin
      slot_full_nxt[ret_r] = 1'b1;
      ret_nxt = (ret_r == LAST_PTR) ? '0 : ret_r + 1'b1;
    end
    if ((op_t'(op) == OP_RELEASE) && !do_store && (corr_r != CORR_MAX)) begin
      corr_nxt = corr_r + 1'b1;
    end
  end

  // free count from the updated pointers
  always_comb begin
    priority if (take_nxt < ret_nxt) begin
      free_cnt = CNT_W'(ret_nxt) - CNT_W'(take_nxt);
    end else if (take_nxt > ret_nxt) begin
      free_cnt = FULL_CNT - CNT_W'(take_nxt) + CNT_W'(ret_nxt);
    end else begin
      free_cnt = slot_full_nxt[take_nxt] ? FULL_CNT : '0;
    end
  end

  // result record
  always_comb begin
    res.ok            = do_alloc || do_store;
    res.buffer_index  = do_alloc ? slot_idx_r[take_r] : '0;
    res.free_count    = free_cnt;
    res.corrupt_count = corr_nxt;
  end

  // ring state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUFFERS; i++) begin
        slot_idx_r[i] <= IDX_W'(i);
      end
      slot_full_r <= '1;
      take_r      <= '0;
      ret_r       <= '0;
      corr_r      <= '0;
    end else if (exec) begin
      if (do_store) begin
        slot_idx_r[ret_r] <= rel_index;
      end
      slot_full_r <= slot_full_nxt;
      take_r      <= take_nxt;
      ret_r       <= ret_nxt;
      corr_r      <= corr_nxt;
    end
  end

endmodule

// ----- hdl/ring_free_list_allocator.sv -----
// top level of the ring free-list allocator
// input register, ring core and result register; depends on rfl_pkg and rfl_ring
//
//   channel   direction  ports                                         handshake
//   in_       input      op, release_index                             valid / stall
//   out_      output     ok, buffer_index, free_count, corrupt_count   valid / stall
//
// one request per cycle sustained while out_stall is low; request and result are registered
// the single-pass ring update between the input and result registers sets the rate
// reset (synchronous, active low) empties both registers and puts buffer i in slot i
// an output stall holds the result register and, once the input register is also
// full, stalls the input; stall on the input follows out_stall in the same cycle
module ring_free_list_allocator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic [rfl_pkg::IDX_W-1:0]  in_release_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_ok,
  output logic [rfl_pkg::IDX_W-1:0]  out_buffer_index,
  output logic [rfl_pkg::CNT_W-1:0]  out_free_count,
  output logic [rfl_pkg::CORR_W-1:0] out_corrupt_count
);
  import rfl_pkg::*;

  logic             in_valid_r;
  logic             op_r;
  logic [IDX_W-1:0] rel_r;
  logic             out_valid_r;
  res_t             res_r;
  res_t             res;
  logic             advance;
  logic             in_load;

  // request moves into the result register when that slot frees up
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_load  = !in_valid_r || advance;
  assign in_stall = !in_load;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_load) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      op_r  <= in_op;
      rel_r <= in_release_index;
    end
  end

  // ring core
  rfl_ring u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .exec      (advance),
    .op        (op_r),
    .rel_index (rel_r),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      res_r       <= '0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
      res_r       <= res;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = res_r.ok;
  assign out_buffer_index  = res_r.buffer_index;
  assign out_free_count    = res_r.free_count;
  assign out_corrupt_count = res_r.corrupt_count;

endmodule

// ----- hdl/rfl_checker.sv -----
// port-level checks for the ring free-list allocator
// bound to ring_free_list_allocator; depends on rfl_pkg
module rfl_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_ok,
  input logic [rfl_pkg::IDX_W-1:0]  out_buffer_index,
  input logic [rfl_pkg::CNT_W-1:0]  out_free_count,
  input logic [rfl_pkg::CORR_W-1:0] out_corrupt_count
);
  import rfl_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BUFFERS);

  // refused request never reports a buffer
  a_fail_no_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_buffer_index == '0)
    else $error("failed request reports a buffer number");

  // free count never exceeds the pool
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_free_count <= FULL_CNT)
    else $error("free count beyond pool size");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ok) &&
      $stable(out_buffer_index) && $stable(out_free_count) &&
      $stable(out_corrupt_count))
    else $error("stalled result changed");

  // corruption count never goes down
  a_corr_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> out_corrupt_count >= $past(out_corrupt_count))
    else $error("corruption count went down");

endmodule

bind ring_free_list_allocator rfl_checker u_rfl_checker (.*);
